### hw/rtl/mlbt_pkg.sv
package mlbt_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int MAC_W = 48;
  localparam int PORT_W = 4;
  localparam int TIME_W = 48;

  typedef enum logic [1:0] {
    ACT_FORWARD = 2'd0,
    ACT_FLOOD   = 2'd1,
    ACT_FILTER  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_INJECT,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic [MAC_W-1:0]  src_mac;
    logic [MAC_W-1:0]  dst_mac;
    logic [PORT_W-1:0] in_port;
    logic [TIME_W-1:0] now;
  } frame_t;

  typedef struct packed {
    action_t           action;
    logic [PORT_W-1:0] out_port;
  } result_t;

  // Lookup keys and staleness limit, broadcast to every cell
  typedef struct packed {
    logic [MAC_W-1:0]  src_mac;
    logic [MAC_W-1:0]  dst_mac;
    logic [TIME_W-1:0] lim;
    logic              lim_ok;
  } probe_t;

  // Accumulated scan result, handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              src_hit;
    logic [IDX_W-1:0]  src_idx;
    logic [PORT_W-1:0] src_port;
    logic              dst_hit;
    logic [PORT_W-1:0] dst_port;
    logic              stale_found;
    logic [IDX_W-1:0]  stale_idx;
    logic [TIME_W-1:0] stale_time;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
  } token_t;

  // Table update, broadcast to every cell
  typedef struct packed {
    logic              refresh_en;
    logic [IDX_W-1:0]  refresh_idx;
    logic              kill_en;
    logic [IDX_W-1:0]  kill_idx;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
    logic [TIME_W-1:0] now;
  } commit_t;

endpackage

### hw/rtl/mlbt_cell.sv
module mlbt_cell import mlbt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] idx,
  input  probe_t           probe,
  input  commit_t          cmt,
  input  token_t           tok_in,
  output token_t           tok_out
);

  logic              valid;
  logic [MAC_W-1:0]  mac;
  logic [PORT_W-1:0] port;
  logic [TIME_W-1:0] last_seen;

  token_t tok_q;
  token_t tok_next;

  logic hit_src;
  logic hit_dst;
  logic stale;

  // Compare this entry against the broadcast keys
  always_comb begin
    stale   = valid && probe.lim_ok && (last_seen < probe.lim);
    hit_src = valid && (mac == probe.src_mac);
    hit_dst = valid && (mac == probe.dst_mac) && !stale;
  end

  // Fold this entry into the passing token; earlier cells win ties
  always_comb begin
    tok_next = tok_in;
    if (hit_src && !tok_in.src_hit) begin
      tok_next.src_hit  = 1'b1;
      tok_next.src_idx  = idx;
      tok_next.src_port = port;
    end
    if (hit_dst && !tok_in.dst_hit) begin
      tok_next.dst_hit  = 1'b1;
      tok_next.dst_port = port;
    end
    if (stale && (!tok_in.stale_found || (last_seen < tok_in.stale_time))) begin
      tok_next.stale_found = 1'b1;
      tok_next.stale_idx   = idx;
      tok_next.stale_time  = last_seen;
    end
    if (!valid && !tok_in.free_found) begin
      tok_next.free_found = 1'b1;
      tok_next.free_idx   = idx;
    end
  end

  // Hand the token to the neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q.valid <= 1'b0;
    end else begin
      tok_q <= tok_next;
    end
  end

  assign tok_out = tok_q;

  // Track occupancy; a write after a kill at the same slot wins
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      if (cmt.kill_en && (cmt.kill_idx == idx)) begin
        valid <= 1'b0;
      end
      if (cmt.wr_en && (cmt.wr_idx == idx)) begin
        valid <= 1'b1;
      end
    end
  end

  // Store entry contents
  always_ff @(posedge clk) begin
    if (cmt.wr_en && (cmt.wr_idx == idx)) begin
      mac       <= cmt.mac;
      port      <= cmt.port;
      last_seen <= cmt.now;
    end else if (cmt.refresh_en && (cmt.refresh_idx == idx)) begin
      last_seen <= cmt.now;
    end
  end

endmodule

### hw/rtl/mac_learning_bridge_table.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    in_data   (frame_t)
// out       output     out_valid/out_ready  out_data  (result_t)
// cfg       input      cfg_wr_en            cfg_wr_data (aging time)
//
// A new frame is accepted only after the previous one has finished its update:
// the scan token walks the chain of cells one entry per cycle.
// Reset clears all valid bits at once; the table is usable right after reset.
// A held result stalls only the final update step, never the scan.
module mac_learning_bridge_table import mlbt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  frame_t            in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output result_t           out_data,
  input  logic              cfg_wr_en,
  input  logic [TIME_W-1:0] cfg_wr_data
);

  state_t state;
  state_t state_next;

  logic [TIME_W-1:0] aging_time;
  frame_t            frame;
  logic [TIME_W-1:0] lim;
  logic              lim_ok;
  token_t            fin;

  logic inject;
  logic load_lim;
  logic load_fin;
  logic do_commit;

  probe_t  probe;
  commit_t cmt;
  token_t  tok_inject;
  token_t  tin [TABLE_ENTRIES];
  token_t  tok [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] tok_valid_vec;

  logic             alloc_ok;
  logic [IDX_W-1:0] alloc_idx;
  result_t          res;

  // Hold the aging time
  always_ff @(posedge clk) begin
    if (rst) begin
      aging_time <= TIME_W'(1000000);
    end else if (cfg_wr_en) begin
      aging_time <= cfg_wr_data;
    end
  end

  // Sequence one frame through scan and update
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_PREP;
      ST_PREP:   state_next = ST_INJECT;
      ST_INJECT: state_next = ST_SCAN;
      ST_SCAN:   if (tok[TABLE_ENTRIES-1].valid) state_next = ST_COMMIT;
      ST_COMMIT: if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    load_lim  = 1'b0;
    inject    = 1'b0;
    load_fin  = 1'b0;
    do_commit = 1'b0;
    unique case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_PREP:   load_lim = 1'b1;
      ST_INJECT: inject = 1'b1;
      ST_SCAN:   load_fin = tok[TABLE_ENTRIES-1].valid;
      ST_COMMIT: do_commit = !out_valid || out_ready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the frame, the staleness limit and the finished token
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      frame <= in_data;
    end
    if (load_lim) begin
      lim_ok <= frame.now > aging_time;
      lim    <= frame.now - aging_time;
    end
    if (load_fin) begin
      fin <= tok[TABLE_ENTRIES-1];
    end
  end

  always_comb begin
    probe.src_mac = frame.src_mac;
    probe.dst_mac = frame.dst_mac;
    probe.lim     = lim;
    probe.lim_ok  = lim_ok;
  end

  always_comb begin
    tok_inject       = '0;
    tok_inject.valid = inject;
  end

  // Row of cells, one table entry each
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign tin[i] = tok_inject;
    end else begin : g_link
      assign tin[i] = tok[i-1];
    end
    assign tok_valid_vec[i] = tok[i].valid;
    mlbt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (IDX_W'(i)),
      .probe   (probe),
      .cmt     (cmt),
      .tok_in  (tin[i]),
      .tok_out (tok[i])
    );
  end

  // Pick the slot for a new source: lowest free after the reclaim
  always_comb begin
    alloc_ok  = 1'b0;
    alloc_idx = fin.free_idx;
    if (fin.free_found && (!fin.stale_found || (fin.free_idx < fin.stale_idx))) begin
      alloc_ok = 1'b1;
    end else if (fin.stale_found) begin
      alloc_ok  = 1'b1;
      alloc_idx = fin.stale_idx;
    end
  end

  always_comb begin
    cmt.refresh_en  = do_commit && fin.src_hit;
    cmt.refresh_idx = fin.src_idx;
    cmt.kill_en     = do_commit && !fin.src_hit && fin.stale_found;
    cmt.kill_idx    = fin.stale_idx;
    cmt.wr_en       = do_commit && !fin.src_hit && alloc_ok;
    cmt.wr_idx      = alloc_idx;
    cmt.mac         = frame.src_mac;
    cmt.port        = frame.in_port;
    cmt.now         = frame.now;
  end

  // Decide forwarding; a destination equal to the source sees the update
  always_comb begin
    res.action   = ACT_FLOOD;
    res.out_port = '0;
    if (frame.dst_mac == frame.src_mac) begin
      if (fin.src_hit) begin
        if (fin.src_port != frame.in_port) begin
          res.action   = ACT_FORWARD;
          res.out_port = fin.src_port;
        end else begin
          res.action = ACT_FILTER;
        end
      end else if (alloc_ok) begin
        res.action = ACT_FILTER;
      end
    end else if (fin.dst_hit) begin
      if (fin.dst_port != frame.in_port) begin
        res.action   = ACT_FORWARD;
        res.out_port = fin.dst_port;
      end else begin
        res.action = ACT_FILTER;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_commit) begin
      out_data <= res;
    end
  end

  // At most one scan token in flight
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_valid_vec))
    else $error("more than one scan token in the chain");

  // No token in the chain while waiting for a frame
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> tok_valid_vec == '0)
    else $error("scan token present while idle");

  // A known source is refreshed, never written anew
  a_refresh_excl: assert property (@(posedge clk) disable iff (rst)
    cmt.refresh_en |-> !cmt.wr_en && !cmt.kill_en)
    else $error("refresh overlaps a learn or reclaim");

  // Each commit leaves a result behind
  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    do_commit |=> out_valid && state == ST_IDLE)
    else $error("commit did not deliver a result");

endmodule
